FILE: hw/rtl/lsqe_pkg.sv
// Shared types, constants and helpers for the line segment quad extruder.
// The front end, the queue, the offset unit and the back end all use this package.
// It has no dependencies.
package lsqe_pkg;

    localparam logic [30:0] LINE_WIDTH_RESET = 31'd1048576;
    localparam logic [30:0] HALF_LIMIT = 31'h4000_0000;

    localparam logic [1:0] CORNER_START_PLUS  = 2'd0;
    localparam logic [1:0] CORNER_START_MINUS = 2'd1;
    localparam logic [1:0] CORNER_END_MINUS   = 2'd2;
    localparam logic [1:0] CORNER_END_PLUS    = 2'd3;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } seg_in_t;

    typedef struct packed {
        logic signed [31:0] vertex_x;
        logic signed [31:0] vertex_y;
        logic signed [31:0] vertex_z;
        logic [1:0]         corner;
        logic               degenerate;
        logic               last;
    } vtx_out_t;

    typedef struct packed {
        seg_in_t     seg;
        logic [31:0] adx;
        logic [31:0] adz;
        logic        dx_neg;
        logic        dz_pos;
        logic        degen;
    } seg_work_t;

    // Adds or subtracts an offset and clamps to the signed 32-bit range.
    function automatic logic [31:0] sat_add(input logic [31:0] base,
                                            input logic [31:0] offs,
                                            input logic        sub);
        logic [32:0] sum;
        begin
            if (sub)
            begin
                sum = {base[31], base} - {offs[31], offs};
            end
            else
            begin
                sum = {base[31], base} + {offs[31], offs};
            end
            if (sum[32] != sum[31])
            begin
                sat_add = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else
            begin
                sat_add = sum[31:0];
            end
        end
    endfunction

endpackage

FILE: hw/rtl/lsqe_fifo.sv
// Two-entry queue of classified segments between the front and back ends.
// Depends on lsqe_pkg for the seg_work_t record.
module lsqe_fifo
    import lsqe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  seg_work_t push_data,
    output logic      push_ready,
    input  logic      pop,
    output logic      pop_valid,
    output seg_work_t pop_data
);

    seg_work_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: hw/rtl/lsqe_front.sv
// Front end: takes input beats, forms the horizontal direction and classifies it.
// Depends on lsqe_pkg; feeds lsqe_fifo.
module lsqe_front
    import lsqe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  seg_in_t   in_data,
    output logic      push,
    output seg_work_t push_data,
    input  logic      push_ready
);

    logic        stage_valid_reg;
    seg_work_t   stage_reg;
    seg_work_t   work;
    logic [32:0] dx;
    logic [32:0] dz;
    logic [32:0] adx_wide;
    logic [32:0] adz_wide;
    logic        take;

    assign dx = {in_data.end_x[31], in_data.end_x} - {in_data.start_x[31], in_data.start_x};
    assign dz = {in_data.end_z[31], in_data.end_z} - {in_data.start_z[31], in_data.start_z};
    assign adx_wide = dx[32] ? (33'd0 - dx) : dx;
    assign adz_wide = dz[32] ? (33'd0 - dz) : dz;

    always_comb
    begin
        work.seg    = in_data;
        work.adx    = adx_wide[31:0];
        work.adz    = adz_wide[31:0];
        work.dx_neg = dx[32];
        work.dz_pos = !dz[32] && (dz != 33'd0);
        work.degen  = (dx == 33'd0) && (dz == 33'd0);
    end

    assign in_ready  = !stage_valid_reg || push_ready;
    assign take      = in_valid && in_ready;
    assign push      = stage_valid_reg;
    assign push_data = stage_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg <= work;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

endmodule

FILE: hw/rtl/lsqe_offset.sv
// Offset magnitude unit: round(num * w / (2 * sqrt(num^2 + oth^2))), computed exactly.
// Forms six products on one 32x32 multiplier, then runs a bit-by-bit search.
// Depends on lsqe_pkg.
module lsqe_offset
    import lsqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] oth,
    input  logic [30:0] width,
    output logic        done,
    output logic [30:0] mag
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_INIT = 2'd2;
    localparam logic [1:0] ST_SRCH = 2'd3;
    localparam logic [4:0] MUL_LAST = 5'd6;
    localparam logic [4:0] BIT_TOP  = 5'd30;

    logic [1:0]   state_reg;
    logic [4:0]   cnt_reg;
    logic         done_reg;
    logic         top_reg;
    logic [31:0]  num_reg;
    logic [31:0]  oth_reg;
    logic [30:0]  w_reg;
    logic [63:0]  prod_reg;
    logic [62:0]  nw_reg;
    logic [65:0]  s_reg;
    logic [127:0] p_reg;
    logic [131:0] r_reg;
    logic [131:0] x_reg;
    logic [131:0] y_reg;
    logic [131:0] z_reg;
    logic [30:0]  q_reg;
    logic [31:0]  mul_a;
    logic [31:0]  mul_b;
    logic [131:0] delta;
    logic [131:0] trial;
    logic [131:0] x_upd;
    logic         pass;

    always_comb
    begin
        unique case (cnt_reg)
            5'd0:
            begin
                mul_a = num_reg;
                mul_b = {1'b0, w_reg};
            end
            5'd1:
            begin
                mul_a = num_reg;
                mul_b = num_reg;
            end
            5'd2:
            begin
                mul_a = oth_reg;
                mul_b = oth_reg;
            end
            5'd3:
            begin
                mul_a = nw_reg[31:0];
                mul_b = nw_reg[31:0];
            end
            5'd4:
            begin
                mul_a = nw_reg[31:0];
                mul_b = {1'b0, nw_reg[62:32]};
            end
            5'd5:
            begin
                mul_a = {1'b0, nw_reg[62:32]};
                mul_b = {1'b0, nw_reg[62:32]};
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    // Trial residual for setting bit k of q: P - S*(2q'-1)^2 with q' = q + 2^k.
    assign delta = x_reg + y_reg - z_reg;
    assign trial = r_reg - delta;
    assign pass  = !trial[131] && !top_reg;
    assign x_upd = pass ? (x_reg + {y_reg[130:0], 1'b0}) : x_reg;

    assign done = done_reg;
    assign mag  = q_reg;

    always_ff @(posedge clk)
    begin
        if (start && state_reg == ST_IDLE)
        begin
            num_reg <= num;
            oth_reg <= oth;
            w_reg   <= width;
        end
        prod_reg <= {32'd0, mul_a} * {32'd0, mul_b};
        if (state_reg == ST_MUL)
        begin
            case (cnt_reg)
                5'd1: nw_reg <= prod_reg[62:0];
                5'd2: s_reg  <= {2'b00, prod_reg};
                5'd3: s_reg  <= s_reg + {2'b00, prod_reg};
                5'd4: p_reg  <= {64'd0, prod_reg};
                5'd5: p_reg  <= p_reg + {31'd0, prod_reg, 33'd0};
                5'd6: p_reg  <= p_reg + {prod_reg, 64'd0};
                default: p_reg <= p_reg;
            endcase
        end
        else if (state_reg == ST_INIT)
        begin
            r_reg <= {4'd0, p_reg} - {66'd0, s_reg};
            x_reg <= 132'd0;
            y_reg <= {4'd0, s_reg, 62'd0};
            z_reg <= {34'd0, s_reg, 32'd0};
        end
        else if (state_reg == ST_SRCH)
        begin
            if (pass)
            begin
                r_reg <= trial;
            end
            x_reg <= x_upd >> 1;
            y_reg <= y_reg >> 2;
            z_reg <= z_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 5'd0;
            done_reg  <= 1'b0;
            top_reg   <= 1'b0;
            q_reg     <= 31'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= 5'd0;
                    if (start)
                    begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    if (cnt_reg == MUL_LAST)
                    begin
                        state_reg <= ST_INIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                ST_INIT:
                begin
                    cnt_reg   <= BIT_TOP;
                    q_reg     <= 31'd0;
                    top_reg   <= 1'b0;
                    state_reg <= ST_SRCH;
                end
                ST_SRCH:
                begin
                    if (pass)
                    begin
                        q_reg[cnt_reg] <= 1'b1;
                        if (cnt_reg == BIT_TOP)
                        begin
                            top_reg <= 1'b1;
                        end
                    end
                    if (cnt_reg == 5'd0)
                    begin
                        state_reg <= ST_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - 5'd1;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/lsqe_back.sv
// Back end: pops a classified segment, runs the two offset units and emits four corners.
// Depends on lsqe_pkg and lsqe_offset.
module lsqe_back
    import lsqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [30:0] line_width,
    input  logic        pop_valid,
    input  seg_work_t   pop_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output vtx_out_t    out_data
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_CALC = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  corner_reg;
    logic        out_valid_reg;
    vtx_out_t    out_reg;
    seg_work_t   work_reg;
    logic [31:0] ox_reg;
    logic [31:0] oz_reg;
    logic        start;
    logic        done_x;
    logic        done_z;
    logic [30:0] mag_x;
    logic [30:0] mag_z;
    logic [31:0] mx_ext;
    logic [31:0] mz_ext;
    logic        load;
    logic        at_end;
    logic        minus;
    vtx_out_t    vtx;

    assign start = (state_reg == B_IDLE) && pop_valid;
    assign pop   = start;

    lsqe_offset u_off_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (pop_data.adz),
        .oth   (pop_data.adx),
        .width (line_width),
        .done  (done_x),
        .mag   (mag_x)
    );

    lsqe_offset u_off_z (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .num   (pop_data.adx),
        .oth   (pop_data.adz),
        .width (line_width),
        .done  (done_z),
        .mag   (mag_z)
    );

    assign mx_ext = work_reg.degen ? 32'd0 : {1'b0, mag_x};
    assign mz_ext = work_reg.degen ? 32'd0 : {1'b0, mag_z};

    assign load   = (state_reg == B_EMIT) && (!out_valid_reg || out_ready);
    assign at_end = corner_reg[1];
    assign minus  = (corner_reg == CORNER_START_MINUS) || (corner_reg == CORNER_END_MINUS);

    always_comb
    begin
        vtx.vertex_x   = sat_add(at_end ? work_reg.seg.end_x : work_reg.seg.start_x,
                                 ox_reg, minus);
        vtx.vertex_y   = at_end ? work_reg.seg.end_y : work_reg.seg.start_y;
        vtx.vertex_z   = sat_add(at_end ? work_reg.seg.end_z : work_reg.seg.start_z,
                                 oz_reg, minus);
        vtx.corner     = corner_reg;
        vtx.degenerate = work_reg.degen;
        vtx.last       = (corner_reg == CORNER_END_PLUS);
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= pop_data;
        end
        if (state_reg == B_CALC && done_x)
        begin
            ox_reg <= work_reg.dz_pos ? (32'd0 - mx_ext) : mx_ext;
            oz_reg <= work_reg.dx_neg ? (32'd0 - mz_ext) : mz_ext;
        end
        if (load)
        begin
            out_reg <= vtx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            corner_reg    <= CORNER_START_PLUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    corner_reg <= CORNER_START_PLUS;
                    if (start)
                    begin
                        state_reg <= B_CALC;
                    end
                end
                B_CALC:
                begin
                    if (done_x)
                    begin
                        state_reg <= B_EMIT;
                    end
                end
                B_EMIT:
                begin
                    if (load)
                    begin
                        corner_reg <= corner_reg + 2'd1;
                        if (corner_reg == CORNER_END_PLUS)
                        begin
                            state_reg <= B_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // Both offset units start together and take the same number of cycles.
    a_done_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        done_x == done_z)
        else $error("offset units out of step");

    // No offset magnitude exceeds half of the largest width.
    a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_x |-> (mag_x <= HALF_LIMIT) && (mag_z <= HALF_LIMIT))
        else $error("offset magnitude out of range");

    // A segment is only popped while the back end is idle and no corner is pending.
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == B_CALC) && (corner_reg == CORNER_START_PLUS))
        else $error("pop outside idle");

    // A degenerate segment leaves every corner on its endpoint.
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        load && work_reg.degen |-> (ox_reg == 32'd0) && (oz_reg == 32'd0))
        else $error("degenerate segment with nonzero offset");

endmodule

FILE: hw/rtl/line_segment_quad_extruder_core.sv
// Line segment quad extruder, top level.
//
// Input channel in_valid/in_ready/in_data carries one beat per segment: start and
// end points, signed Q16.16. Output channel out_valid/out_ready/out_data carries
// four beats per segment, the quad corners in the order start+offset, start-offset,
// end-offset, end+offset, with last set on the fourth.
// cfg_we/cfg_wdata write the full line width (unsigned Q16.16); write only while idle.
// The front end registers and classifies a segment, a two-entry queue decouples it
// from the back end, so new segments are taken while corners are still draining.
// From input beat to first corner, a segment passes the front stage and the queue,
// then two offset units run side by side, each forming its products on one 32x32
// multiplier, taking one setup step and running a bit-by-bit search; the corners then
// leave at one per cycle while the receiver accepts them. The back end holds a segment
// until its fourth corner is loaded and takes no new segment before then.
// Reset clears the queue and all valid flags and loads the width with 16.0.
// When the receiver stalls, the current corner holds in the output register,
// the back end waits, and the queue and front stage fill before in_ready drops.
// Depends on lsqe_pkg, lsqe_front, lsqe_fifo and lsqe_back.
module line_segment_quad_extruder_core
    import lsqe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  seg_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output vtx_out_t    out_data,
    input  logic        cfg_we,
    input  logic [30:0] cfg_wdata
);

    logic [30:0] line_width_reg;
    logic        push;
    logic        push_ready;
    seg_work_t   push_data;
    logic        pop;
    logic        pop_valid;
    seg_work_t   pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            line_width_reg <= cfg_wdata;
        end
    end

    lsqe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready)
    );

    lsqe_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data)
    );

    lsqe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (line_width_reg),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

FILE: verif/line_segment_quad_extruder_core_tb.sv
// Self-checking testbench for line_segment_quad_extruder_core: it drives segments, predicts
// the four quad corners of each one and compares every corner beat against that prediction.
// It depends on lsqe_pkg and the core RTL only.
module line_segment_quad_extruder_core_tb;
    import lsqe_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int DRAIN_CYCLES  = 60;
    localparam int RANDOM_ITEMS  = 240;
    localparam int CALM_ITEMS    = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    seg_in_t     in_data;
    logic        out_valid;
    logic        out_ready;
    vtx_out_t    out_data;
    logic        cfg_we;
    logic [30:0] cfg_wdata;

    logic [30:0] width_shadow;
    logic        calm;
    int          cycles;
    int          ready_hold;
    int          seg_count;
    int          width_count;

    line_segment_quad_extruder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Largest q with (2q-1)^2 * (num^2 + oth^2) <= (num*w)^2, which is round-half-up of
    // num*w / (2*length) computed exactly.
    function automatic logic [31:0] half_projection(logic [32:0] num, logic [32:0] oth,
                                                    logic [30:0] w);
        logic [63:0]  nw;
        logic [129:0] rhs;
        logic [129:0] lhs;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  q;
        logic [31:0]  t;
        nw  = {31'b0, num} * {33'b0, w};
        rhs = {66'b0, nw} * {66'b0, nw};
        lo  = 32'd0;
        hi  = 32'h4000_0000;
        while (lo < hi)
        begin
            q = (lo + hi + 32'd1) >> 1;
            t = 32'd2 * q - 32'd1;
            a = {32'b0, t} * {31'b0, num};
            b = {32'b0, t} * {31'b0, oth};
            lhs = {66'b0, a} * {66'b0, a} + {66'b0, b} * {66'b0, b};
            if (lhs <= rhs)
            begin
                lo = q;
            end
            else
            begin
                hi = q - 32'd1;
            end
        end
        return lo;
    endfunction

    class corner_scoreboard;
        vtx_out_t expected_corners[$];
        int       mismatches;
        int       corners_checked;

        function void note_segment(seg_in_t s, logic [30:0] w);
            longint     dx;
            longint     dz;
            longint     ox;
            longint     oz;
            longint     mag_x;
            longint     mag_z;
            logic       degen;
            vtx_out_t   v;
            longint     sgn;
            dx = longint'(s.end_x) - longint'(s.start_x);
            dz = longint'(s.end_z) - longint'(s.start_z);
            ox = 0;
            oz = 0;
            degen = (dx == 0) && (dz == 0);
            if (!degen)
            begin
                mag_x = longint'(half_projection(33'(dz < 0 ? -dz : dz),
                                                 33'(dx < 0 ? -dx : dx), w));
                mag_z = longint'(half_projection(33'(dx < 0 ? -dx : dx),
                                                 33'(dz < 0 ? -dz : dz), w));
                ox = dz > 0 ? -mag_x : mag_x;
                oz = dx < 0 ? -mag_z : mag_z;
            end
            for (int k = 0; k < 4; k++)
            begin
                sgn = (k == 0 || k == 3) ? 1 : -1;
                v.vertex_x   = clamp32((k >= 2 ? longint'(s.end_x) : longint'(s.start_x))
                                       + sgn * ox);
                v.vertex_y   = k >= 2 ? s.end_y : s.start_y;
                v.vertex_z   = clamp32((k >= 2 ? longint'(s.end_z) : longint'(s.start_z))
                                       + sgn * oz);
                v.corner     = k[1:0];
                v.degenerate = degen;
                v.last       = (k[1:0] == CORNER_END_PLUS);
                expected_corners.push_back(v);
            end
        endfunction

        function void check_corner(vtx_out_t got);
            vtx_out_t want;
            corners_checked++;
            if (expected_corners.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Unexpected corner beat: %p", got);
                end
                return;
            end
            want = expected_corners.pop_front();
            if (got.vertex_x !== want.vertex_x || got.vertex_y !== want.vertex_y ||
                got.vertex_z !== want.vertex_z || got.corner !== want.corner ||
                got.degenerate !== want.degenerate || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("Corner mismatch: expected %p, actual %p", want, got);
                end
            end
        endfunction

        function int pending();
            return expected_corners.size();
        endfunction
    endclass

    corner_scoreboard sb = new();

    initial
    begin
        clk = 0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Run exceeded the cycle limit with %0d corners pending.", sb.pending());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_segment(in_data, width_shadow);
            seg_count++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_corner(out_data);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || calm)
        begin
            out_ready  <= 1'b1;
            ready_hold <= 0;
        end
        else if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            out_ready  <= (ready_hold == 1);
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            ready_hold <= $urandom_range(1, 5);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_segment(seg_in_t s);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic drain_and_configure(logic [30:0] w);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we       <= 1'b0;
        width_shadow <= w;
        width_count++;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic seg_in_t random_segment();
        seg_in_t s;
        logic [31:0] span;
        s.start_x = pick_coord();
        s.start_y = $urandom();
        s.start_z = pick_coord();
        s.end_y   = $urandom();
        span = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 32'h0008_0000);
        case ($urandom_range(0, 9))
            0:
            begin
                s.end_x = s.start_x;
                s.end_z = s.start_z;
            end
            1:
            begin
                s.end_x = s.start_x;
                s.end_z = pick_coord();
            end
            2:
            begin
                s.end_x = pick_coord();
                s.end_z = s.start_z;
            end
            3:
            begin
                s.end_x = pick_coord();
                s.end_z = pick_coord();
            end
            default:
            begin
                s.end_x = s.start_x + span - (span >> 1) * ($urandom_range(0, 1) ? 2 : 0);
                s.end_z = s.start_z + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            end
        endcase
        return s;
    endfunction

    function automatic seg_in_t make_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                                             logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
        seg_in_t s;
        s.start_x = sx;
        s.start_y = sy;
        s.start_z = sz;
        s.end_x   = ex;
        s.end_y   = ey;
        s.end_z   = ez;
        return s;
    endfunction

    task automatic directed_set();
        send_segment(make_segment(0, 0, 0, 32'h0001_0000, 0, 0));
        send_segment(make_segment(0, 0, 0, 0, 0, 32'h0001_0000));
        send_segment(make_segment(0, 0, 0, 32'hFFFF_0000, 0, 0));
        send_segment(make_segment(0, 0, 0, 0, 0, 32'hFFFF_0000));
        send_segment(make_segment(0, 5, 0, 32'h0003_0000, 7, 32'h0004_0000));
        send_segment(make_segment(1, 2, 3, 1, 32'h7FFF_FFFF, 3));
        send_segment(make_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 0, 32'h8000_0000));
        send_segment(make_segment(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF,
                                  32'h7FFF_FFF0, 0, 32'h7FFF_FFFF));
        send_segment(make_segment(32'h8000_0000, 0, 32'h8000_0000,
                                  32'h8000_0000, 0, 32'h8000_0010));
        send_segment(make_segment(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_segment(make_segment(32'h7FFF_FFFF, 0, 32'h8000_0000,
                                  32'h8000_0000, 0, 32'h7FFF_FFFF));
        send_segment(make_segment(0, 0, 0, 1, 0, 1));
        send_segment(make_segment(0, 0, 0, 1, 0, 0));
        send_segment(make_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  0, 0, 0));
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        width_shadow = LINE_WIDTH_RESET;
        calm         = 1'b0;
        cycles       = 0;
        ready_hold   = 0;
        seg_count    = 0;
        width_count  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_set();
        drain_and_configure(31'd0);
        directed_set();
        drain_and_configure(31'h7FFF_FFFF);
        directed_set();
        drain_and_configure(31'd1);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 59)
            begin
                case ($urandom_range(0, 3))
                    0: drain_and_configure(31'h7FFF_FFFF);
                    1: drain_and_configure(31'($urandom_range(0, 31'h0100_0000)));
                    2: drain_and_configure(31'($urandom()));
                    default: drain_and_configure(LINE_WIDTH_RESET);
                endcase
            end
            if (i == RANDOM_ITEMS - CALM_ITEMS)
            begin
                calm <= 1'b1;
            end
            send_segment(random_segment());
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d corners from %0d segments across %0d line widths.",
                 sb.corners_checked, seg_count, width_count + 1);
        $display("Mismatches counted: %0d.", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
